// ===== rtl/tsrpe_pkg.sv =====
`default_nettype none

package tsrpe_pkg;

    localparam int ROW_WIDTH_MAX_DEF = 1024;
    localparam int ROWS_MAX_DEF      = 1024;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int RIGHT_LIMIT_W = 10;
    localparam int LEFT_LIMIT_W  = 11;

    localparam logic [RIGHT_LIMIT_W-1:0]       RIGHT_LIMIT_RST = 10'd100;
    localparam logic signed [LEFT_LIMIT_W-1:0] LEFT_LIMIT_RST  = -11'sd100;

    // register index = paddr[2]
    localparam logic REG_RIGHT_LIMIT = 1'b0;
    localparam logic REG_LEFT_LIMIT  = 1'b1;

    localparam logic [7:0] PIX_BLACK = 8'd0;
    localparam logic [7:0] PIX_GREY  = 8'd128;
    localparam logic [7:0] PIX_WHITE = 8'd255;

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_BLACK = 2'd1;
    localparam logic [1:0] CLS_GREY  = 2'd2;
    localparam logic [1:0] CLS_WHITE = 2'd3;

    // pattern positions
    localparam logic [1:0] POS_IDLE      = 2'd0;
    localparam logic [1:0] POS_GREY_NEXT = 2'd1;
    localparam logic [1:0] POS_MID       = 2'd2;
    localparam logic [1:0] POS_DONE      = 2'd3;

    typedef enum logic [1:0] {
        SHAPE_NONE     = 2'd0,
        SHAPE_STRAIGHT = 2'd1,
        SHAPE_RIGHT    = 2'd2,
        SHAPE_LEFT     = 2'd3
    } t_shape;

    function automatic logic [1:0] pixel_class(input logic [7:0] v);
        logic [1:0] c;
        case (v)
            PIX_BLACK: c = CLS_BLACK;
            PIX_GREY:  c = CLS_GREY;
            PIX_WHITE: c = CLS_WHITE;
            default:   c = CLS_OTHER;
        endcase
        return c;
    endfunction

    // class expected at each position of the white, grey, white pattern
    function automatic logic [1:0] pattern_expect(input logic [1:0] pos);
        logic [1:0] c;
        case (pos)
            POS_IDLE:      c = CLS_WHITE;
            POS_GREY_NEXT: c = CLS_GREY;
            POS_MID:       c = CLS_WHITE;
            default:       c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/track_shape_run_pattern_estimator.sv =====
// Track shape estimator.
// Input channel (i_in_valid / o_in_ready): one grey pixel per request, row by
// row, with end_of_row on the last pixel of each row and end_of_frame on the
// last pixel of the frame (it also ends the row). Each row is split into runs
// of equal value; the white, grey, white run pattern is tracked and the
// midpoint of the grey run is recorded (upper on the first matched row, lower
// afterwards).
// Output channel (o_out_valid / i_out_ready): one request per frame, carrying
// the shape code and the count of matched rows.
// Throughput: one pixel per cycle while no end_of_frame pixel is stalled. A
// pixel is held in an input register, then one pass of run closing, pattern
// step and end-of-frame classification writes the state and the result
// register. o_out_valid is registered and rises as the end_of_frame pixel leaves the input register.
// A stalled receiver only blocks an end_of_frame pixel that would overwrite a
// waiting result; while that pixel waits, the input stalls behind it.
// APB port: right_limit at 0x0, left_limit at 0x4; pready is tied high.
// Reset (synchronous, i_rst_n low) restores the limits to +100 / -100 and
// clears all frame state; no clearing pass is needed.
`default_nettype none

module track_shape_run_pattern_estimator #(
    parameter int ROW_WIDTH_MAX = tsrpe_pkg::ROW_WIDTH_MAX_DEF,
    parameter int ROWS_MAX      = tsrpe_pkg::ROWS_MAX_DEF,
    parameter int CW            = $clog2(ROWS_MAX + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_pixel,
    input  wire logic                          i_end_of_row,
    input  wire logic                          i_end_of_frame,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_track_shape,
    output logic [CW-1:0]                      o_matched_rows,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsrpe_pkg::APB_AW-1:0]  paddr,
    input  wire logic [tsrpe_pkg::APB_DW-1:0]  pwdata,
    output logic [tsrpe_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);

    localparam int CLW = $clog2(ROW_WIDTH_MAX);
    localparam int DW  = (CLW + 1 > 12) ? CLW + 1 : 12;
    localparam int AW  = CW + 4;
    localparam logic [CLW-1:0] COL_MAX  = CLW'(ROW_WIDTH_MAX - 1);
    localparam logic [CW-1:0]  ROWS_SAT = CW'(ROWS_MAX);

    typedef struct packed {
        logic [1:0]     pos;
        logic           matched;
        logic           first_seen;
        logic           lower_seen;
        logic [CLW-1:0] upper_mid;
        logic [CLW-1:0] lower_mid;
        logic [CW-1:0]  good_rows;
    } t_pat;

    function automatic t_pat close_run(input t_pat s, input logic [1:0] cls,
                                       input logic [CLW-1:0] rs,
                                       input logic [CLW-1:0] re,
                                       input logic last);
        t_pat       r;
        logic [CLW:0] sum;
        r   = s;
        sum = {1'b0, rs} + {1'b0, re};
        if (!s.matched) begin
            if (tsrpe_pkg::pattern_expect(s.pos) != cls) begin
                r.pos = (cls == tsrpe_pkg::CLS_WHITE) ? tsrpe_pkg::POS_GREY_NEXT
                                                      : tsrpe_pkg::POS_IDLE;
            end else begin
                r.pos = s.pos + 2'd1;
                if (r.pos == tsrpe_pkg::POS_MID) begin
                    if (!s.first_seen) begin
                        r.upper_mid = sum[CLW:1];
                    end else begin
                        r.lower_mid  = sum[CLW:1];
                        r.lower_seen = 1'b1;
                    end
                end
                if (r.pos == tsrpe_pkg::POS_DONE) begin
                    r.matched    = 1'b1;
                    r.first_seen = 1'b1;
                end
            end
        end
        if (last && r.matched) begin
            if (r.good_rows != ROWS_SAT) begin
                r.good_rows = r.good_rows + CW'(1);
            end
            r.matched = 1'b0;
            r.pos     = tsrpe_pkg::POS_IDLE;
        end
        return r;
    endfunction

    // configuration
    logic [tsrpe_pkg::RIGHT_LIMIT_W-1:0]       r_right_limit;
    logic signed [tsrpe_pkg::LEFT_LIMIT_W-1:0] r_left_limit;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_pix;
    logic       r_s1_eor;
    logic       r_s1_eof;

    // frame state
    logic [7:0]     r_prev_pixel, n_prev_pixel;
    logic           r_have_prev, n_have_prev;
    logic [CLW-1:0] r_column, n_column;
    logic [CLW-1:0] r_run_start, n_run_start;
    logic [CW-1:0]  r_row_total, n_row_total;
    t_pat           r_pat, n_pat;

    // result register
    logic              r_out_valid;
    tsrpe_pkg::t_shape r_shape, n_shape;
    logic [CW-1:0]     r_matched;

    logic s1_adv;

    logic [CLW:0]          col_inc;
    logic [CLW-1:0]        col;
    logic [AW-1:0]         good_x10;
    logic [AW-1:0]         total_x7;
    logic signed [DW-1:0]  up_mid;
    logic signed [DW-1:0]  lo_mid;
    logic signed [DW-1:0]  diff;
    logic signed [DW-1:0]  rl;
    logic signed [DW-1:0]  ll;

    assign s1_adv     = r_s1_valid && (!r_s1_eof || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            tsrpe_pkg::REG_RIGHT_LIMIT:
                prdata = {{(tsrpe_pkg::APB_DW - tsrpe_pkg::RIGHT_LIMIT_W){1'b0}},
                          r_right_limit};
            default:
                prdata = {{(tsrpe_pkg::APB_DW - tsrpe_pkg::LEFT_LIMIT_W)
                           {r_left_limit[tsrpe_pkg::LEFT_LIMIT_W-1]}}, r_left_limit};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_limit <= tsrpe_pkg::RIGHT_LIMIT_RST;
            r_left_limit  <= tsrpe_pkg::LEFT_LIMIT_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                tsrpe_pkg::REG_RIGHT_LIMIT:
                    r_right_limit <= pwdata[tsrpe_pkg::RIGHT_LIMIT_W-1:0];
                default:
                    r_left_limit <= pwdata[tsrpe_pkg::LEFT_LIMIT_W-1:0];
            endcase
        end
    end

    always_comb begin
        n_prev_pixel = r_prev_pixel;
        n_have_prev  = r_have_prev;
        n_column     = r_column;
        n_run_start  = r_run_start;
        n_row_total  = r_row_total;
        n_pat        = r_pat;
        n_shape      = tsrpe_pkg::SHAPE_NONE;

        col_inc = {1'b0, r_column} + {{CLW{1'b0}}, 1'b1};
        if (!r_have_prev) begin
            col         = '0;
            n_run_start = '0;
        end else begin
            col = (col_inc > {1'b0, COL_MAX}) ? COL_MAX : col_inc[CLW-1:0];
            if (r_s1_pix != r_prev_pixel) begin
                n_pat = close_run(n_pat, tsrpe_pkg::pixel_class(r_prev_pixel),
                                  r_run_start, r_column, 1'b0);
                n_run_start = col;
            end
        end
        n_column     = col;
        n_prev_pixel = r_s1_pix;
        n_have_prev  = 1'b1;

        if (r_s1_eor || r_s1_eof) begin
            n_pat = close_run(n_pat, tsrpe_pkg::pixel_class(r_s1_pix),
                              n_run_start, col, 1'b1);
            if (r_row_total != ROWS_SAT) begin
                n_row_total = r_row_total + CW'(1);
            end
            n_have_prev = 1'b0;
            n_column    = '0;
            n_run_start = '0;
        end

        // 10*good >= 7*total, by shifts, adds and a subtract
        good_x10 = {1'b0, n_pat.good_rows, 3'b000} + {2'b00, n_pat.good_rows, 1'b0};
        total_x7 = {1'b0, n_row_total, 3'b000} - {4'b0000, n_row_total};

        up_mid = {{(DW - CLW){1'b0}}, n_pat.upper_mid};
        lo_mid = n_pat.lower_seen ? {{(DW - CLW){1'b0}}, n_pat.lower_mid} : up_mid;
        diff   = up_mid - lo_mid;
        rl     = {{(DW - tsrpe_pkg::RIGHT_LIMIT_W){1'b0}}, r_right_limit};
        ll     = {{(DW - tsrpe_pkg::LEFT_LIMIT_W){r_left_limit[tsrpe_pkg::LEFT_LIMIT_W-1]}},
                  r_left_limit};

        if (n_row_total != '0 && good_x10 >= total_x7) begin
            if (ll <= diff && diff <= rl) begin
                n_shape = tsrpe_pkg::SHAPE_STRAIGHT;
            end else if (diff > rl) begin
                n_shape = tsrpe_pkg::SHAPE_RIGHT;
            end else if (diff < ll) begin
                n_shape = tsrpe_pkg::SHAPE_LEFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_pix <= i_pixel;
            r_s1_eor <= i_end_of_row;
            r_s1_eof <= i_end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pixel <= '0;
            r_have_prev  <= 1'b0;
            r_column     <= '0;
            r_run_start  <= '0;
            r_row_total  <= '0;
            r_pat        <= '0;
        end else if (s1_adv) begin
            if (r_s1_eof) begin
                // next frame starts from reset state
                r_prev_pixel <= '0;
                r_have_prev  <= 1'b0;
                r_column     <= '0;
                r_run_start  <= '0;
                r_row_total  <= '0;
                r_pat        <= '0;
            end else begin
                r_prev_pixel <= n_prev_pixel;
                r_have_prev  <= n_have_prev;
                r_column     <= n_column;
                r_run_start  <= n_run_start;
                r_row_total  <= n_row_total;
                r_pat        <= n_pat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_eof) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_eof) begin
            r_shape   <= n_shape;
            r_matched <= n_pat.good_rows;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_track_shape  = r_shape;
    assign o_matched_rows = r_matched;

    // an end-of-frame pixel waits while an earlier result is unread
    a_eof_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_eof && r_out_valid && !i_out_ready)
            |=> (r_s1_valid && r_s1_eof && r_out_valid))
        else $error("end-of-frame request overran a pending result");

    a_match_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat.matched == (r_pat.pos == tsrpe_pkg::POS_DONE))
        else $error("row match flag out of step with pattern position");

    a_rows_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat.good_rows <= r_row_total)
        else $error("matched rows exceed total rows");

    a_lower_after_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat.lower_seen |-> r_pat.first_seen)
        else $error("lower midpoint recorded before first match");

endmodule

`default_nettype wire
